>>> sv/ultrasonic_fill_level_fan_control_top_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic_fill_level_fan_control_top_defines
// assertion macros shared by the fill level block
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_FILL_LEVEL_FAN_CONTROL_TOP_DEFINES_SVH
`define ULTRASONIC_FILL_LEVEL_FAN_CONTROL_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define UFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufl assertion failed");

// next-cycle implication, reset masks the check
`define UFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufl assertion failed");

`endif

>>> sv/ufl_pkg.sv
// ----------------------------------------------------------------------------
// ufl_pkg
// types and constants of the ultrasonic fill level block
// ----------------------------------------------------------------------------
package ufl_pkg;

    // echo fields carried by one item
    localparam int unsigned NUM_FIELDS      = 4;
    localparam int unsigned ECHO_W          = 15;
    localparam int unsigned ECHO_TIMEOUT_US = 30000;

    // merged lane results
    localparam int unsigned SUM_W   = 18;
    localparam int unsigned COUNT_W = 3;

    // shared divider geometry
    localparam int unsigned DIV_NUM_W = 27;
    localparam int unsigned DIV_DEN_W = 15;
    localparam int unsigned DIV_Q_W   = 14;

    // configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DIST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_OFF_THR = 3'd4;

    // one lane's finding
    typedef struct packed {
        logic              ok;
        logic [ECHO_W-1:0] echo;
    } t_lane;

    // what the merge stage hands to the sequencer
    typedef struct packed {
        logic [SUM_W-1:0]      sum;
        logic [COUNT_W-1:0]    count;
        logic [NUM_FIELDS-1:0] mask;
    } t_merge;

endpackage

>>> sv/ufl_lane.sv
// ----------------------------------------------------------------------------
// ufl_lane
// checks one echo against the timeout and passes on its duration
// ----------------------------------------------------------------------------
module ufl_lane (
    input  logic [ufl_pkg::ECHO_W-1:0] i_echo,
    output ufl_pkg::t_lane             o_lane
);

    logic w_ok;

    // nonzero and not beyond the timeout
    assign w_ok = (i_echo != '0) &&
                  ({1'b0, i_echo} <= 16'(ufl_pkg::ECHO_TIMEOUT_US));

    assign o_lane.ok   = w_ok;
    assign o_lane.echo = w_ok ? i_echo : '0;

endmodule

>>> sv/ufl_merge.sv
// ----------------------------------------------------------------------------
// ufl_merge
// combines the lanes into echo sum, working count and sensor mask
// ----------------------------------------------------------------------------
module ufl_merge (
    input  ufl_pkg::t_lane  i_lanes [ufl_pkg::NUM_FIELDS],
    output ufl_pkg::t_merge o_merge
);

    logic [ufl_pkg::SUM_W-1:0]      w_sum;
    logic [ufl_pkg::COUNT_W-1:0]    w_count;
    logic [ufl_pkg::NUM_FIELDS-1:0] w_mask;

    // sum and count over the lanes
    always_comb begin
        w_sum   = '0;
        w_count = '0;
        for (int i = 0; i < ufl_pkg::NUM_FIELDS; i++) begin
            w_sum     = w_sum + ufl_pkg::SUM_W'(i_lanes[i].echo);
            w_count   = w_count + ufl_pkg::COUNT_W'(i_lanes[i].ok);
            w_mask[i] = i_lanes[i].ok;
        end
    end

    assign o_merge.sum   = w_sum;
    assign o_merge.count = w_count;
    assign o_merge.mask  = w_mask;

endmodule

>>> sv/ufl_div.sv
// ----------------------------------------------------------------------------
// ufl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ufl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ufl_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [ufl_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [ufl_pkg::DIV_Q_W-1:0]   o_quot
);

    localparam int unsigned QW = ufl_pkg::DIV_Q_W;
    localparam int unsigned DW = ufl_pkg::DIV_DEN_W;
    localparam int unsigned NW = ufl_pkg::DIV_NUM_W;
    localparam int unsigned CW = $clog2(QW);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW+1:0] w_trial;

    // trial subtract of the shifted remainder
    assign w_trial = {1'b0, r_rem, r_quot[QW-1]} - {2'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: high numerator bits seed the remainder, low bits shift through
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DW'(i_num[NW-1:QW]);
            r_quot <= i_num[QW-1:0];
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_trial[DW+1]) begin
                r_rem <= w_trial[DW-1:0];
            end else begin
                r_rem <= {r_rem[DW-2:0], r_quot[QW-1]};
            end
            r_quot <= {r_quot[QW-2:0], !w_trial[DW+1]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> sv/ultrasonic_fill_level_fan_control_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_fill_level_fan_control_top
// averages four ultrasonic echoes into a distance and a fill percentage,
// and runs fan on/off hysteresis on the fill level
// ----------------------------------------------------------------------------
//  channel   valid / ready                 payload
//  input     i_valid / o_ready             i_echo_us_0 .. i_echo_us_3
//  output    o_valid / i_ready             o_distance_q4, o_fill_percent,
//                                          o_fill_valid, o_sensors_ok_count,
//                                          o_sensor_ok_mask, o_fan_on
//  config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  an item runs through scale, distance divide, clamp, fill divide and done;
//  the fill divide is skipped when the calibration is inverted, and an item
//  with no sensor answering goes straight to done. the shared divider works
//  distance, then fill. one item is in work at a time; a finished result sits
//  in the output register while the next item is taken. reset is synchronous,
//  active low, and loads the register defaults with the fan off. a stalled
//  output holds the sequencer in its last state until the register frees.
// ----------------------------------------------------------------------------
`include "ultrasonic_fill_level_fan_control_top_defines.svh"

module ultrasonic_fill_level_fan_control_top #(
    parameter int unsigned SENSOR_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_0,
    input  logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_1,
    input  logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_2,
    input  logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_3,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [13:0]                   o_distance_q4,
    output logic [6:0]                    o_fill_percent,
    output logic                          o_fill_valid,
    output logic [2:0]                    o_sensors_ok_count,
    output logic [3:0]                    o_sensor_ok_mask,
    output logic                          o_fan_on,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ufl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ufl_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned LANES =
        (SENSOR_COUNT < ufl_pkg::NUM_FIELDS) ? SENSOR_COUNT : ufl_pkg::NUM_FIELDS;
    localparam int unsigned NW = ufl_pkg::DIV_NUM_W;
    localparam int unsigned DW = ufl_pkg::DIV_DEN_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_DDIV  = 7'b0000100,
        S_CLAMP = 7'b0001000,
        S_FGO   = 7'b0010000,
        S_FDIV  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [ufl_pkg::ECHO_W-1:0] w_echo [ufl_pkg::NUM_FIELDS];
    ufl_pkg::t_lane             w_lanes [ufl_pkg::NUM_FIELDS];
    ufl_pkg::t_merge            w_merge;

    // configuration registers
    logic       r_auto;
    logic [8:0] r_empty;
    logic [8:0] r_full;
    logic [6:0] r_on_thr;
    logic [6:0] r_off_thr;

    // item in work
    logic [ufl_pkg::SUM_W-1:0]      r_sum;
    logic [ufl_pkg::COUNT_W-1:0]    r_cnt;
    logic [ufl_pkg::NUM_FIELDS-1:0] r_mask;
    logic [13:0]                    r_dq4;
    logic [6:0]                     r_fill;
    logic                           r_fvalid;
    logic [12:0]                    r_diff;
    logic [12:0]                    r_span;
    logic                           r_fan, n_fan;

    // output register
    logic        r_out_valid;
    logic [13:0] r_out_dq4;
    logic [6:0]  r_out_fill;
    logic        r_out_fvalid;
    logic [2:0]  r_out_cnt;
    logic [3:0]  r_out_mask;

    logic          w_in_xfer;
    logic          w_out_load;
    logic          w_div_start;
    logic [NW-1:0] w_div_num;
    logic [DW-1:0] w_div_den;
    logic          w_div_done;
    logic [ufl_pkg::DIV_Q_W-1:0] w_div_quot;
    logic [12:0]   w_e;
    logic [12:0]   w_f;
    logic [12:0]   w_c;

    // lanes, one per used sensor field
    assign w_echo[0] = i_echo_us_0;
    assign w_echo[1] = i_echo_us_1;
    assign w_echo[2] = i_echo_us_2;
    assign w_echo[3] = i_echo_us_3;

    for (genvar g = 0; g < ufl_pkg::NUM_FIELDS; g++) begin : g_lane
        if (g < LANES) begin : g_used
            ufl_lane u_lane (
                .i_echo (w_echo[g]),
                .o_lane (w_lanes[g])
            );
        end else begin : g_unused
            assign w_lanes[g] = '0;
        end
    end

    ufl_merge u_merge (
        .i_lanes (w_lanes),
        .o_merge (w_merge)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto    <= 1'b1;
            r_empty   <= 9'd100;
            r_full    <= 9'd10;
            r_on_thr  <= 7'd80;
            r_off_thr <= 7'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ufl_pkg::CFG_AUTO_MODE:   r_auto    <= i_cfg_data[0];
                ufl_pkg::CFG_EMPTY_DIST:  r_empty   <= i_cfg_data[8:0];
                ufl_pkg::CFG_FULL_DIST:   r_full    <= i_cfg_data[8:0];
                ufl_pkg::CFG_FAN_ON_THR:  r_on_thr  <= i_cfg_data[6:0];
                ufl_pkg::CFG_FAN_OFF_THR: r_off_thr <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // handshake decode
    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // calibration points in sixteenths of a cm, clamped distance
    assign w_e = {r_empty, 4'b0};
    assign w_f = {r_full, 4'b0};

    always_comb begin
        if (r_dq4 < {1'b0, w_f}) begin
            w_c = w_f;
        end else if (r_dq4 > {1'b0, w_e}) begin
            w_c = w_e;
        end else begin
            w_c = r_dq4[12:0];
        end
    end

    // shared divider: distance first, then fill
    assign w_div_start = (r_state == S_SCALE) || (r_state == S_FGO);

    always_comb begin
        if (r_state == S_FGO) begin
            w_div_num = NW'({14'd0, r_diff} * 27'd200) + NW'(r_span);
            w_div_den = {1'b0, r_span, 1'b0};
        end else begin
            w_div_num = NW'({9'd0, r_sum} * 27'd686) + NW'({10'd0, r_cnt} * 13'd1250);
            w_div_den = DW'({12'd0, r_cnt} * 15'd2500);
        end
    end

    ufl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (w_merge.count == '0) ? S_DONE : S_SCALE;
                end
            end
            S_SCALE: n_state = S_DDIV;
            S_DDIV:  if (w_div_done) n_state = S_CLAMP;
            S_CLAMP: n_state = (w_e <= w_f) ? S_DONE : S_FGO;
            S_FGO:   n_state = S_FDIV;
            S_FDIV:  if (w_div_done) n_state = S_DONE;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // fan hysteresis on a valid fill in automatic mode
    always_comb begin
        n_fan = r_fan;
        if (r_fvalid && r_auto) begin
            if (!r_fan && (r_fill >= r_on_thr)) begin
                n_fan = 1'b1;
            end else if (r_fan && (r_fill <= r_off_thr)) begin
                n_fan = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fan       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_fan       <= n_fan;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum    <= w_merge.sum;
                r_cnt    <= w_merge.count;
                r_mask   <= w_merge.mask;
                r_dq4    <= '0;
                r_fill   <= '0;
                r_fvalid <= 1'b0;
            end
            S_DDIV: begin
                r_dq4 <= w_div_quot;
            end
            S_CLAMP: begin
                r_fvalid <= 1'b1;
                r_fill   <= 7'd100;
                r_diff   <= w_e - w_c;
                r_span   <= w_e - w_f;
            end
            S_FDIV: begin
                r_fill <= w_div_quot[6:0];
            end
            default: ;
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_dq4    <= r_dq4;
            r_out_fill   <= r_fill;
            r_out_fvalid <= r_fvalid;
            r_out_cnt    <= r_cnt;
            r_out_mask   <= r_mask;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_distance_q4      = r_out_dq4;
    assign o_fill_percent     = r_out_fill;
    assign o_fill_valid       = r_out_fvalid;
    assign o_sensors_ok_count = r_out_cnt;
    assign o_sensor_ok_mask   = r_out_mask;
    assign o_fan_on           = r_fan;

    // checks
    `UFL_ASSERT_NOW(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `UFL_ASSERT_NOW(a_mask_count, i_clk, i_rst_n, o_valid,
        $countones(o_sensor_ok_mask) == 32'(o_sensors_ok_count))
    `UFL_ASSERT_NOW(a_no_echo_zero, i_clk, i_rst_n, o_valid && !o_fill_valid,
        (o_fill_percent == 7'd0) && (o_distance_q4 == 14'd0))
    `UFL_ASSERT_NEXT(a_fan_held, i_clk, i_rst_n, !w_out_load, $stable(r_fan))

endmodule

>>> dv/tb_ultrasonic_fill_level_fan_control_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_fill_level_fan_control_top
// self-checking bench for the ultrasonic fill level and fan control block:
// drives echo sets over the input channel, rewrites the calibration and fan
// registers between phases, predicts distance, fill level, sensor mask and
// fan hysteresis for every accepted transfer, and compares each result
// transfer field by field, with random idling and a long output stall
// ----------------------------------------------------------------------------
module tb_ultrasonic_fill_level_fan_control_top;

    localparam int unsigned CLK_HALF_NS  = 5;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned TIMEOUT_NS   = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_REPORTS  = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 135;
    localparam int unsigned NUM_PHASES   = 7;
    // echo time in us for roughly one cm of range
    localparam int unsigned US_PER_CM    = 58;
    localparam int unsigned ECHO_MAX     = (1 << ufl_pkg::ECHO_W) - 1;
    // register indexes with nothing behind them
    localparam logic [ufl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE =
        ufl_pkg::CFG_FAN_OFF_THR + 3'd1;
    localparam logic [ufl_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;

    typedef logic [ufl_pkg::NUM_FIELDS-1:0][ufl_pkg::ECHO_W-1:0] t_echo_set;

    typedef struct packed {
        logic [13:0] distance_q4;
        logic [6:0]  fill_percent;
        logic        fill_valid;
        logic [2:0]  ok_count;
        logic [3:0]  ok_mask;
        logic        fan_on;
    } t_level_rpt;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_0;
    logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_1;
    logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_2;
    logic [ufl_pkg::ECHO_W-1:0]    i_echo_us_3;
    logic                          o_valid;
    logic                          i_ready;
    logic [13:0]                   o_distance_q4;
    logic [6:0]                    o_fill_percent;
    logic                          o_fill_valid;
    logic [2:0]                    o_sensors_ok_count;
    logic [3:0]                    o_sensor_ok_mask;
    logic                          o_fan_on;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ufl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ufl_pkg::CFG_DAT_W-1:0] i_cfg_data;

    // predicted results waiting for their transfer
    t_level_rpt  pending_levels[$];
    int unsigned mismatch_cnt = 0;
    bit          stall_on = 1'b0;
    bit          gap_on = 1'b0;
    int unsigned rx_hold = 0;

    // shadow of the register file and the fan flag
    logic       mdl_auto     = 1'b1;
    logic [8:0] mdl_empty_cm = 9'd100;
    logic [8:0] mdl_full_cm  = 9'd10;
    logic [6:0] mdl_on_thr   = 7'd80;
    logic [6:0] mdl_off_thr  = 7'd50;
    logic       mdl_fan      = 1'b0;

    ultrasonic_fill_level_fan_control_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_echo_us_0        (i_echo_us_0),
        .i_echo_us_1        (i_echo_us_1),
        .i_echo_us_2        (i_echo_us_2),
        .i_echo_us_3        (i_echo_us_3),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_distance_q4      (o_distance_q4),
        .o_fill_percent     (o_fill_percent),
        .o_fill_valid       (o_fill_valid),
        .o_sensors_ok_count (o_sensors_ok_count),
        .o_sensor_ok_mask   (o_sensor_ok_mask),
        .o_fan_on           (o_fan_on),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF_NS i_clk = ~i_clk;

    // averaged distance, fill level and fan hysteresis for one echo set
    function automatic t_level_rpt predict_level(input t_echo_set echo);
        t_level_rpt  r;
        logic [31:0] sum, cnt, dq4, e_q4, f_q4, c_q4, span, fill;
        logic [3:0]  mask;
        sum  = '0;
        cnt  = '0;
        dq4  = '0;
        fill = '0;
        mask = '0;
        for (int i = 0; i < ufl_pkg::NUM_FIELDS; i++) begin
            if (echo[i] != '0 && 32'(echo[i]) <= ufl_pkg::ECHO_TIMEOUT_US) begin
                sum     = sum + 32'(echo[i]);
                cnt     = cnt + 32'd1;
                mask[i] = 1'b1;
            end
        end
        if (cnt != '0) begin
            // 0.01715 cm/us in sixteenths, rounded half up
            dq4  = (sum * 32'd686 + 32'd1250 * cnt) / (32'd2500 * cnt);
            e_q4 = 32'(mdl_empty_cm) * 32'd16;
            f_q4 = 32'(mdl_full_cm) * 32'd16;
            if (e_q4 <= f_q4) begin
                fill = 32'd100;
            end else begin
                c_q4 = (dq4 < f_q4) ? f_q4 : (dq4 > e_q4) ? e_q4 : dq4;
                span = e_q4 - f_q4;
                fill = ((e_q4 - c_q4) * 32'd200 + span) / (32'd2 * span);
            end
            if (mdl_auto) begin
                if (!mdl_fan && fill >= 32'(mdl_on_thr))
                    mdl_fan = 1'b1;
                else if (mdl_fan && fill <= 32'(mdl_off_thr))
                    mdl_fan = 1'b0;
            end
        end
        r.distance_q4  = dq4[13:0];
        r.fill_percent = fill[6:0];
        r.fill_valid   = (cnt != '0);
        r.ok_count     = cnt[2:0];
        r.ok_mask      = mask;
        r.fan_on       = mdl_fan;
        return r;
    endfunction

    // register write as the block sees it
    function automatic void store_reg(input logic [ufl_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ufl_pkg::CFG_DAT_W-1:0] data);
        case (idx)
            ufl_pkg::CFG_AUTO_MODE:   mdl_auto     = data[0];
            ufl_pkg::CFG_EMPTY_DIST:  mdl_empty_cm = data[8:0];
            ufl_pkg::CFG_FULL_DIST:   mdl_full_cm  = data[8:0];
            ufl_pkg::CFG_FAN_ON_THR:  mdl_on_thr   = data[6:0];
            ufl_pkg::CFG_FAN_OFF_THR: mdl_off_thr  = data[6:0];
            default: ;
        endcase
    endfunction

    // random echo set, mostly clustered around the calibrated range
    function automatic t_echo_set rand_echoes();
        t_echo_set   e;
        logic [31:0] lo, hi, target, pick, v;
        lo = (mdl_full_cm < mdl_empty_cm) ? 32'(mdl_full_cm) : 32'(mdl_empty_cm);
        hi = (mdl_full_cm < mdl_empty_cm) ? 32'(mdl_empty_cm) : 32'(mdl_full_cm);
        target = $urandom_range((lo > 32'd5) ? lo - 32'd5 : 32'd0, hi + 32'd5) * US_PER_CM;
        if ($urandom_range(0, 24) == 0)
            return '0;
        for (int i = 0; i < ufl_pkg::NUM_FIELDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                v = '0;
            else if (pick < 16)
                v = $urandom_range(ufl_pkg::ECHO_TIMEOUT_US + 1, ECHO_MAX);
            else if (pick < 20)
                v = $urandom_range(0, ECHO_MAX);
            else if (pick < 23)
                v = pick[0] ? 32'd1 : 32'(ufl_pkg::ECHO_TIMEOUT_US);
            else
                v = target + $urandom_range(0, 120);
            e[i] = v[ufl_pkg::ECHO_W-1:0];
        end
        return e;
    endfunction

    // one input transfer; valid stays up for a following item unless a random gap drops it
    task automatic send_echoes(input t_echo_set echo);
        i_valid     <= 1'b1;
        i_echo_us_0 <= echo[0];
        i_echo_us_1 <= echo[1];
        i_echo_us_2 <= echo[2];
        i_echo_us_3 <= echo[3];
        do @(posedge i_clk); while (!o_ready);
        pending_levels.push_back(predict_level(echo));
        if (gap_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_flat(input logic [ufl_pkg::ECHO_W-1:0] v);
        send_echoes({ufl_pkg::NUM_FIELDS{v}});
    endtask

    // one register transfer; valid stays up for a following write
    task automatic reg_write(input logic [ufl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ufl_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        store_reg(idx, data);
    endtask

    task automatic load_regs(input logic [ufl_pkg::CFG_DAT_W-1:0] auto_d, empty_d,
                             full_d, on_d, off_d);
        reg_write(ufl_pkg::CFG_AUTO_MODE, auto_d);
        reg_write(ufl_pkg::CFG_EMPTY_DIST, empty_d);
        reg_write(ufl_pkg::CFG_FULL_DIST, full_d);
        reg_write(ufl_pkg::CFG_FAN_ON_THR, on_d);
        reg_write(ufl_pkg::CFG_FAN_OFF_THR, off_d);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
    endtask

    task automatic test_echo_extremes;
        t_echo_set e;
        send_flat('0);
        send_flat(15'd1);
        send_flat(ufl_pkg::ECHO_W'(ufl_pkg::ECHO_TIMEOUT_US));
        send_flat(ufl_pkg::ECHO_W'(ufl_pkg::ECHO_TIMEOUT_US + 1));
        send_flat(ufl_pkg::ECHO_W'(ECHO_MAX));
        // each sensor answering alone
        for (int i = 0; i < ufl_pkg::NUM_FIELDS; i++) begin
            e    = '0;
            e[i] = 15'd2000;
            send_echoes(e);
        end
        send_echoes({15'd1, 15'd30001, 15'd30000, 15'd0});
        send_echoes({15'h5555, 15'h2AAA, 15'h2AAA, 15'h5555});
    endtask

    task automatic test_fan_hysteresis;
        send_flat(15'd500);    // nearly full, fan on
        send_flat(15'd2680);   // between thresholds, holds
        send_flat('0);         // no echo leaves the fan alone
        send_flat(15'd10000);  // empty, fan off
        send_flat(15'd2680);   // holds off
        send_flat(15'd1000);   // above on threshold again
    endtask

    task automatic test_register_cases;
        wait_drained;
        // unmapped indexes, then manual mode
        reg_write(CFG_IDX_SPARE, '1);
        reg_write(CFG_IDX_LAST, 9'h0AA);
        load_regs(9'h000, 9'd100, 9'd10, 9'd80, 9'd50);
        send_flat(15'd10000);
        send_flat(15'd500);
        // empty not beyond full, thresholds above 100
        wait_drained;
        load_regs(9'h1FF, 9'd5, 9'd20, 9'h1FF, 9'h07F);
        send_flat(15'd500);
        send_flat(15'd2000);
        // smallest span, thresholds at the ends
        wait_drained;
        load_regs(9'd1, 9'd1, 9'd0, 9'd0, 9'd100);
        send_flat(15'd58);
        send_flat(15'd29);
        // one cm span at the far end of the range
        wait_drained;
        load_regs(9'd1, 9'd500, 9'd499, 9'd100, 9'd0);
        send_flat(15'd29100);
        send_flat(ufl_pkg::ECHO_W'(ufl_pkg::ECHO_TIMEOUT_US));
    endtask

    task automatic test_output_backpressure;
        wait_drained;
        rx_hold = HOLD_CYCLES;
        repeat (12) send_echoes(rand_echoes());
    endtask

    task automatic test_random_sweep;
        logic [ufl_pkg::CFG_DAT_W-1:0] a_d, e_d, f_d, on_d, off_d;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained;
            a_d   = ufl_pkg::CFG_DAT_W'($urandom_range(0, 511) | 32'd1);
            e_d   = ufl_pkg::CFG_DAT_W'($urandom_range(2, 511));
            f_d   = ufl_pkg::CFG_DAT_W'($urandom_range(0, 32'(e_d) - 32'd1));
            on_d  = ufl_pkg::CFG_DAT_W'($urandom_range(20, 110));
            off_d = ufl_pkg::CFG_DAT_W'($urandom_range(0, 32'(on_d)));
            on_d  = on_d | ufl_pkg::CFG_DAT_W'($urandom_range(0, 3) << 7);
            off_d = off_d | ufl_pkg::CFG_DAT_W'($urandom_range(0, 3) << 7);
            case (phase)
                1: begin
                    e_d = 9'd1;
                    f_d = 9'd0;
                end
                2: begin
                    e_d = 9'h1FF;
                    f_d = 9'd0;
                end
                3: begin
                    e_d = ufl_pkg::CFG_DAT_W'($urandom_range(0, 300));
                    f_d = ufl_pkg::CFG_DAT_W'($urandom_range(32'(e_d), 511));
                end
                4: a_d = ufl_pkg::CFG_DAT_W'($urandom_range(0, 511) & 32'h1FE);
                default: ;
            endcase
            load_regs(a_d, e_d, f_d, on_d, off_d);
            // the last phase runs without idling
            stall_on = (phase != NUM_PHASES - 1);
            gap_on   = (phase != NUM_PHASES - 1);
            repeat (PHASE_ITEMS) send_echoes(rand_echoes());
        end
        stall_on = 1'b0;
        gap_on   = 1'b0;
    endtask

    // result side ready: long hold on request, else random stall bursts
    initial begin : rx_ready_proc
        int unsigned n;
        i_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold != 0) begin
                n       = rx_hold;
                rx_hold = 0;
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : chk_result
        t_level_rpt want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_levels.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result expected none actual distance %0d",
                             $time, o_distance_q4);
            end else begin
                want = pending_levels.pop_front();
                report_field("distance_q4", 32'(want.distance_q4), 32'(o_distance_q4));
                report_field("fill_percent", 32'(want.fill_percent), 32'(o_fill_percent));
                report_field("fill_valid", 32'(want.fill_valid), 32'(o_fill_valid));
                report_field("sensors_ok_count", 32'(want.ok_count),
                             32'(o_sensors_ok_count));
                report_field("sensor_ok_mask", 32'(want.ok_mask), 32'(o_sensor_ok_mask));
                report_field("fan_on", 32'(want.fan_on), 32'(o_fan_on));
            end
        end
    end

    // hang guard
    initial begin
        #TIMEOUT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_echo_us_0 = '0;
        i_echo_us_1 = '0;
        i_echo_us_2 = '0;
        i_echo_us_3 = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_echo_extremes;
        test_fan_hysteresis;
        test_register_cases;
        test_output_backpressure;
        test_random_sweep;

        wait_drained;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_levels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
